[rtl/core/console_line_editor_unit_defines.svh]
// ----------------------------------------------------------------------------
// Console line editor - assertion macros
// Shared property wrappers for the line editor RTL.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_LINE_EDITOR_UNIT_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define CLE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cle_pkg.sv]
// ----------------------------------------------------------------------------
// Console line editor package
// Sizes, character codes, result kinds and shared types.
// ----------------------------------------------------------------------------
package cle_pkg;

   localparam int LINE_CAPACITY = 4096;
   localparam int ADDR_W        = $clog2(LINE_CAPACITY);
   localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
   localparam int WANT_W        = 7;
   localparam int MAX_READ      = 64;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_SP  = 8'h20;

   localparam logic CMD_RX   = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] KIND_ECHO      = 2'd0;
   localparam logic [1:0] KIND_LINE      = 2'd1;
   localparam logic [1:0] KIND_NOT_READY = 2'd2;
   localparam logic [1:0] KIND_REFUSED   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEND,
      ST_RD_ISSUE,
      ST_RD_EMIT
   } cle_state_type;

   typedef enum logic [2:0] {
      MSG_PLAIN,
      MSG_NEWLINE,
      MSG_ERASE,
      MSG_REFUSE,
      MSG_NOLINE
   } cle_msg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
   } cle_beat_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } cle_ram_req_type;

   function automatic cle_beat_type msg_beat(cle_msg_type msg, logic [7:0] ch,
                                             logic [1:0] step);
      cle_beat_type b;
      b.kind = KIND_ECHO;
      b.data = 8'h00;
      b.last = 1'b1;
      case (msg)
         MSG_PLAIN: begin
            b.data = ch;
         end
         MSG_NEWLINE: begin
            b.data = (step == 2'd0) ? CH_CR : CH_LF;
            b.last = (step != 2'd0);
         end
         MSG_ERASE: begin
            b.data = (step == 2'd1) ? CH_SP : CH_BS;
            b.last = (step == 2'd2);
         end
         MSG_NOLINE: begin
            b.kind = KIND_NOT_READY;
         end
         default: begin
            b.kind = KIND_REFUSED;
         end
      endcase
      return b;
   endfunction

endpackage

[rtl/core/cle_line_ram.sv]
// ----------------------------------------------------------------------------
// Line store RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cle_line_ram (
   input  logic                      clock,
   input  cle_pkg::cle_ram_req_type  ram_req,
   output logic [7:0]                rd_data
);
   import cle_pkg::*;

   logic [7:0] mem [LINE_CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/cle_seq.sv]
// ----------------------------------------------------------------------------
// Line editor sequencer
// Edits bytes into the line store, echoes, and streams completed lines out.
// ----------------------------------------------------------------------------
`include "console_line_editor_unit_defines.svh"

module cle_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [7:0]                req_rx_byte,
   input  logic [cle_pkg::WANT_W-1:0] req_want,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_data,
   output logic                      rsp_last,
   output cle_pkg::cle_ram_req_type  ram_req,
   input  logic [7:0]                ram_rd_data
);
   import cle_pkg::*;

   cle_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic              done_ff, done_in;
   cle_msg_type       msg_ff, msg_in;
   logic [7:0]        ch_ff, ch_in;
   logic [1:0]        step_ff, step_in;
   logic [WANT_W-1:0] rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic [7:0]        ch;
   logic              is_erase;
   logic [LEN_W-1:0]  len_inc;
   logic [WANT_W-1:0] want_c;
   logic [LEN_W-1:0]  avail;
   logic [WANT_W-1:0] got;
   cle_beat_type      beat;
   logic              load;
   cle_beat_type      load_beat;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ch       = (req_rx_byte == CH_CR) ? CH_LF : req_rx_byte;
   assign is_erase = (ch == CH_BS) || (ch == CH_DEL);
   assign len_inc  = len_ff + LEN_W'(1);
   assign want_c   = (req_want > WANT_W'(MAX_READ)) ? WANT_W'(MAX_READ) : req_want;
   assign avail    = len_ff - pos_ff;
   assign got      = (avail < LEN_W'(want_c)) ? avail[WANT_W-1:0] : want_c;
   assign beat     = msg_beat(msg_ff, ch_ff, step_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_RX) begin
                  if (done_ff || !is_erase || (len_ff != '0)) begin
                     state_in = ST_SEND;
                  end
               end else if (req_want != '0) begin
                  state_in = done_ff ? ST_RD_ISSUE : ST_SEND;
               end
            end
         end
         ST_SEND: begin
            if (out_free && beat.last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_ISSUE: begin
            state_in = ST_RD_EMIT;
         end
         ST_RD_EMIT: begin
            if (out_free) begin
               state_in = (rem_ff == '0) ? ST_IDLE : ST_RD_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      ram_req   = '0;
      len_in    = len_ff;
      pos_in    = pos_ff;
      done_in   = done_ff;
      msg_in    = msg_ff;
      ch_in     = ch_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      load      = 1'b0;
      load_beat = beat;
      case (state_ff)
         ST_IDLE: begin
            step_in = 2'd0;
            if (req_valid) begin
               if (req_cmd == CMD_RX) begin
                  if (done_ff) begin
                     msg_in = MSG_REFUSE;
                  end else if (is_erase) begin
                     msg_in = MSG_ERASE;
                     if (len_ff != '0) begin
                        len_in = len_ff - LEN_W'(1);
                     end
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = len_ff[ADDR_W-1:0];
                     ram_req.wr_data = ch;
                     len_in          = len_inc;
                     ch_in           = ch;
                     msg_in          = (ch == CH_LF) ? MSG_NEWLINE : MSG_PLAIN;
                     if ((ch == CH_LF) || (len_inc == LEN_W'(LINE_CAPACITY))) begin
                        done_in = 1'b1;
                        pos_in  = '0;
                     end
                  end
               end else begin
                  msg_in = MSG_NOLINE;
                  rem_in = got;
               end
            end
         end
         ST_SEND: begin
            if (out_free) begin
               load    = 1'b1;
               step_in = step_ff + 2'd1;
            end
         end
         ST_RD_ISSUE: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = pos_ff[ADDR_W-1:0];
            pos_in          = pos_ff + LEN_W'(1);
            rem_in          = rem_ff - WANT_W'(1);
         end
         ST_RD_EMIT: begin
            load_beat.kind = KIND_LINE;
            load_beat.data = ram_rd_data;
            load_beat.last = (rem_ff == '0);
            if (out_free) begin
               load = 1'b1;
               if ((rem_ff == '0) && (pos_ff >= len_ff)) begin
                  done_in = 1'b0;
                  len_in  = '0;
                  pos_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
      rsp_kind_in  = load ? load_beat.kind : rsp_kind_ff;
      rsp_data_in  = load ? load_beat.data : rsp_data_ff;
      rsp_last_in  = load ? load_beat.last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff      <= msg_in;
      ch_ff       <= ch_in;
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

   `CLE_ASSERT_IMP(a_pos_in_line, clock, reset, 1'b1, pos_ff <= len_ff, "read position past line end")
   `CLE_ASSERT_IMP(a_len_bound, clock, reset, 1'b1, len_ff <= LEN_W'(LINE_CAPACITY), "line length over capacity")
   `CLE_ASSERT_IMP(a_done_nonempty, clock, reset, done_ff, len_ff != '0, "completed line is empty")
   `CLE_ASSERT_IMP(a_full_is_done, clock, reset, len_ff == LEN_W'(LINE_CAPACITY), done_ff, "full line not completed")
   `CLE_ASSERT_NXT(a_issue_then_emit, clock, reset, state_ff == ST_RD_ISSUE, state_ff == ST_RD_EMIT, "read issue not followed by emit")

endmodule

[rtl/core/console_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// Console line editor unit
// Canonical-mode line editor: echo, erase and line release over a line store.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, cmd, rx_byte, want     | in
//   rsp     | rsp_valid/ready, kind, data, last       | out
//
// A beat is taken only while the sequencer is idle. Echo and status beats
// leave one per cycle while rsp is not stalled. Each line byte has a RAM read
// issue state, then an emit state for the registered read data.
// Reset clears length, position and the line-complete flag; the line store
// is not cleared. A stalled rsp channel holds the sequencer in place.
// ----------------------------------------------------------------------------
module console_line_editor_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_cmd,
   input  logic [7:0]                 req_rx_byte,
   input  logic [cle_pkg::WANT_W-1:0] req_want,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_data,
   output logic                       rsp_last
);
   import cle_pkg::*;

   cle_ram_req_type ram_req;
   logic [7:0]      ram_rd_data;

   cle_line_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   cle_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_cmd     (req_cmd),
      .req_rx_byte (req_rx_byte),
      .req_want    (req_want),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_kind    (rsp_kind),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console line editor unit testbench
// Drives keystrokes and read requests into the req channel and keeps its own
// copy of the line buffer. Each rsp beat is checked in order against the
// beats that copy predicts. The run covers directed edits and random lines
// under several idle and backpressure mixes, including a long rsp hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import cle_pkg::*;

   localparam int WDOG_LIMIT     = 2000;
   localparam int TAIL_CYCLES    = 24;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int RANDOM_ITEMS   = 24;

   typedef struct packed {
      logic              cmd;
      logic [7:0]        rx_byte;
      logic [WANT_W-1:0] want;
   } tty_req_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic              req_cmd     = CMD_RX;
   logic [7:0]        req_rx_byte = 8'h00;
   logic [WANT_W-1:0] req_want    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [1:0]        rsp_kind;
   logic [7:0]        rsp_data;
   logic              rsp_last;

   console_line_editor_unit uut (.*);

   always #1 clock = ~clock;

   tty_req_type  tty_requests[$];
   tty_req_type  offer;
   cle_beat_type beats_due[$];
   cle_beat_type head_beat;

   // shadow of the line buffer
   logic [7:0]  line_copy [LINE_CAPACITY];
   int unsigned shadow_len  = 0;
   int unsigned read_pos    = 0;
   bit          shadow_done = 1'b0;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int holdoff_left    = 0;
   bit req_taken       = 1'b0;
   int idle_cycles     = 0;
   int fail_count      = 0;
   int req_beats       = 0;
   int rsp_beats       = 0;
   int lines_freed     = 0;
   int gen_items       = 0;

   function automatic void due(logic [1:0] kind, logic [7:0] data, logic last);
      cle_beat_type b;
      b.kind = kind;
      b.data = data;
      b.last = last;
      beats_due.push_back(b);
   endfunction

   function automatic void edit_line(logic cmd, logic [7:0] rx_byte,
                                     logic [WANT_W-1:0] want);
      logic [7:0]  ch;
      int unsigned n;
      int unsigned got;
      int unsigned i;
      if (cmd == CMD_RX) begin
         ch = (rx_byte == CH_CR) ? CH_LF : rx_byte;
         if (shadow_done) begin
            due(KIND_REFUSED, 8'h00, 1'b1);
         end else if (ch == CH_BS || ch == CH_DEL) begin
            if (shadow_len != 0) begin
               shadow_len--;
               due(KIND_ECHO, CH_BS, 1'b0);
               due(KIND_ECHO, CH_SP, 1'b0);
               due(KIND_ECHO, CH_BS, 1'b1);
            end
         end else begin
            if (ch == CH_LF) begin
               due(KIND_ECHO, CH_CR, 1'b0);
               due(KIND_ECHO, CH_LF, 1'b1);
            end else begin
               due(KIND_ECHO, ch, 1'b1);
            end
            if (shadow_len < LINE_CAPACITY) begin
               line_copy[ADDR_W'(shadow_len)] = ch;
               shadow_len++;
            end
            if (ch == CH_LF || shadow_len >= LINE_CAPACITY) begin
               shadow_done = 1'b1;
               read_pos    = 0;
            end
         end
      end else if (want != 0) begin
         if (!shadow_done) begin
            due(KIND_NOT_READY, 8'h00, 1'b1);
         end else begin
            n   = (want > MAX_READ) ? MAX_READ : want;
            got = (shadow_len - read_pos < n) ? shadow_len - read_pos : n;
            for (i = 0; i < got; i++)
               due(KIND_LINE, line_copy[ADDR_W'(read_pos + i)], i + 1 == got);
            read_pos += got;
            if (read_pos >= shadow_len) begin
               shadow_done = 1'b0;
               shadow_len  = 0;
               read_pos    = 0;
               lines_freed++;
            end
         end
      end
   endfunction

   // ---------------- stimulus ----------------

   function automatic void put_req(logic cmd, logic [7:0] b, logic [WANT_W-1:0] w,
                                   bit counted);
      tty_req_type r;
      r.cmd     = cmd;
      r.rx_byte = b;
      r.want    = w;
      tty_requests.push_back(r);
      if (counted)
         gen_items++;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL);
      return b;
   endfunction

   // typed line with edits and stray beats, then reads until it is drained
   function automatic void gen_line(int max_chars);
      int n;
      int left;
      int w;
      n    = $urandom_range(0, max_chars);
      left = 0;
      if ($urandom_range(0, 5) == 0)
         put_req(CMD_READ, 8'($urandom), WANT_W'($urandom_range(1, 127)), 1'b1);
      if ($urandom_range(0, 7) == 0)
         put_req(CMD_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL, WANT_W'($urandom), 1'b0);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            put_req(CMD_RX, $urandom_range(0, 1) ? CH_BS : CH_DEL, WANT_W'($urandom),
                    left > 0);
            if (left > 0)
               left--;
         end else begin
            put_req(CMD_RX, plain_char(), WANT_W'($urandom), 1'b1);
            left++;
         end
      end
      put_req(CMD_RX, $urandom_range(0, 1) ? CH_CR : CH_LF, WANT_W'($urandom), 1'b1);
      left++;
      if ($urandom_range(0, 3) == 0)
         put_req(CMD_RX, 8'($urandom), WANT_W'($urandom), 1'b1);
      if ($urandom_range(0, 4) == 0)
         put_req(CMD_READ, 8'($urandom), '0, 1'b0);
      while (left > 0) begin
         if ($urandom_range(0, 6) == 0)
            w = $urandom_range(65, 127);
         else
            w = $urandom_range(1, 64);
         put_req(CMD_READ, 8'($urandom), WANT_W'(w), 1'b1);
         left -= (w > MAX_READ) ? MAX_READ : w;
      end
   endfunction

   function automatic void random_traffic(int items, int max_chars);
      int target;
      target = gen_items + items;
      while (gen_items < target)
         gen_line(max_chars);
   endfunction

   function automatic void directed_edits();
      put_req(CMD_READ, 8'h00, WANT_W'(1), 1'b1);
      put_req(CMD_READ, 8'h00, '0, 1'b0);
      put_req(CMD_RX, CH_BS, '0, 1'b0);
      put_req(CMD_RX, CH_DEL, '0, 1'b0);
      put_req(CMD_RX, 8'h00, '0, 1'b1);
      put_req(CMD_RX, 8'hFF, '1, 1'b1);
      put_req(CMD_RX, 8'h41, '0, 1'b1);
      put_req(CMD_RX, CH_DEL, '0, 1'b1);
      put_req(CMD_RX, CH_BS, '0, 1'b1);
      put_req(CMD_RX, CH_CR, '0, 1'b1);
      put_req(CMD_RX, 8'h55, '0, 1'b1);
      put_req(CMD_RX, CH_BS, '0, 1'b1);
      put_req(CMD_READ, 8'hFF, '0, 1'b0);
      put_req(CMD_READ, 8'h00, WANT_W'(1), 1'b1);
      put_req(CMD_READ, 8'h00, WANT_W'(127), 1'b1);
      put_req(CMD_READ, 8'h00, WANT_W'(MAX_READ), 1'b1);
      put_req(CMD_RX, 8'h7E, '0, 1'b1);
      put_req(CMD_RX, CH_SP, '0, 1'b1);
      put_req(CMD_RX, CH_LF, '0, 1'b1);
      put_req(CMD_READ, 8'h00, WANT_W'(2), 1'b1);
      put_req(CMD_READ, 8'h00, WANT_W'(MAX_READ), 1'b1);
      put_req(CMD_RX, 8'h80, '0, 1'b1);
      put_req(CMD_RX, CH_LF, '0, 1'b1);
      put_req(CMD_READ, 8'h00, WANT_W'(65), 1'b1);
   endfunction

   task automatic settle();
      while (tty_requests.size() != 0 || req_valid || beats_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // ---------------- driver ----------------

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (tty_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            offer = tty_requests.pop_front();
            req_valid   <= 1'b1;
            req_cmd     <= offer.cmd;
            req_rx_byte <= offer.rx_byte;
            req_want    <= offer.want;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // ---------------- monitor ----------------

   function automatic void flag_beat(string what, cle_beat_type exp_beat);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t %s: expected kind %0d data 0x%02h last %0b, %s",
                  $time, what, exp_beat.kind, exp_beat.data, exp_beat.last,
                  $sformatf("got kind %0d data 0x%02h last %0b",
                            rsp_kind, rsp_data, rsp_last));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         // predict before checking, in case a beat leaves in its own cycle
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            req_beats++;
            edit_line(req_cmd, req_rx_byte, req_want);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_beats++;
            if (beats_due.size() == 0) begin
               flag_beat("rsp beat with none due", '0);
            end else begin
               head_beat = beats_due.pop_front();
               if (rsp_kind !== head_beat.kind || rsp_data !== head_beat.data ||
                   rsp_last !== head_beat.last)
                  flag_beat("rsp beat mismatch", head_beat);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d rsp beats still due",
                     idle_cycles, beats_due.size());
            $display("[console_line_editor_unit] ERROR");
            $finish;
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_edits();
      settle();
      random_traffic(RANDOM_ITEMS, 12);
      settle();

      sender_idle_pct = 81;
      random_traffic(RANDOM_ITEMS, 12);
      settle();

      sender_idle_pct = 0;
      rsp_stall_pct   = 81;
      random_traffic(RANDOM_ITEMS, 12);
      settle();

      sender_idle_pct = 30;
      rsp_stall_pct   = 30;
      random_traffic(RANDOM_ITEMS, 12);
      settle();

      // long rsp hold-off while long lines keep coming
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      holdoff_left    = HOLDOFF_CYCLES;
      random_traffic(RANDOM_ITEMS, 48);
      settle();

      $display("covered %0d req beats and %0d rsp beats; %0d lines read out",
               req_beats, rsp_beats, lines_freed);
      $display("idle mixes: none, sender 81%%, receiver 81%%, both 30%%, %0d-cycle rsp hold-off",
               HOLDOFF_CYCLES);
      if (fail_count == 0) begin
         $display("[console_line_editor_unit] OK");
      end else begin
         $display("%0d bad rsp beats", fail_count);
         $display("[console_line_editor_unit] ERROR");
      end
      $finish;
   end

endmodule
